@@ hw/rtl/smpq_pkg.sv @@
package smpq_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 16;
	localparam int FILL_BITS = 5;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int S_TDATA_BITS = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = ((KEY_BITS + TAG_BITS + FILL_BITS + 7) / 8) * 8;
	localparam int M_TUSER_BITS = 3;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	typedef struct packed {
		logic load_item;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

@@ hw/rtl/sorted_min_priority_queue_top.sv @@
// Sorted min-first priority queue of smpq_pkg::CAPACITY entries, each a key and a tag.
// Input items arrive on the s_ stream: s_tuser selects enqueue (0) or dequeue (1),
// s_tdata carries the key and tag of an enqueue. Every input transfer yields exactly
// one result transfer on the m_ stream, in the order of the inputs.
// An enqueue places the entry after all stored entries with a key less than or equal
// to its own, so equal keys leave in arrival order; into a full queue it is dropped
// and the overflow flag is set. A dequeue returns the smallest entry, or sets the
// empty flag. fill_level gives the entry count after the operation.
// Each item passes through two states: the idle state captures it, then the execute
// state compares all slots against the key in parallel, shifts them in a single step
// and writes the result register. No new item is taken while in the execute state.
// The result sits in an output register, so the next item is captured while it
// waits; when the receiver stalls, that item holds in the execute state until the
// result register is free, and s_tready stays low meanwhile.
// Reset empties the queue and clears any pending result; slot contents are not
// cleared, as only slots below the entry count are ever read.
module sorted_min_priority_queue_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Bits from lowest: entry_key, entry_tag.
	input  logic [smpq_pkg::S_TDATA_BITS-1:0]   s_tdata,
	// Bit 0: operation.
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Bits from lowest: out_key, out_tag, fill_level, zero padding.
	output logic [smpq_pkg::M_TDATA_BITS-1:0]   m_tdata,
	// Bits from lowest: out_valid, was_empty, overflow.
	output logic [smpq_pkg::M_TUSER_BITS-1:0]   m_tuser
);

	smpq_pkg::ctrl_cmd_t  cmd;
	smpq_pkg::dp_status_t status;

	smpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	smpq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ hw/rtl/smpq_ctrl.sv @@
module smpq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  smpq_pkg::dp_status_t  status,
	output smpq_pkg::ctrl_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt     = state_q;
		s_tready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.execute   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_nxt     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.out_free) begin
					cmd.execute = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hw/rtl/smpq_dp.sv @@
module smpq_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smpq_pkg::ctrl_cmd_t                 cmd,
	output smpq_pkg::dp_status_t                status,
	input  logic [smpq_pkg::S_TDATA_BITS-1:0]   s_tdata,
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smpq_pkg::M_TDATA_BITS-1:0]   m_tdata,
	output logic [smpq_pkg::M_TUSER_BITS-1:0]   m_tuser
);

	logic                              item_op_q;
	logic [smpq_pkg::KEY_BITS-1:0]     item_key_q;
	logic [smpq_pkg::TAG_BITS-1:0]     item_tag_q;

	logic [smpq_pkg::KEY_BITS-1:0]     key_q   [smpq_pkg::CAPACITY];
	logic [smpq_pkg::TAG_BITS-1:0]     tag_q   [smpq_pkg::CAPACITY];
	logic [smpq_pkg::KEY_BITS-1:0]     key_nxt [smpq_pkg::CAPACITY];
	logic [smpq_pkg::TAG_BITS-1:0]     tag_nxt [smpq_pkg::CAPACITY];
	logic [smpq_pkg::CAPACITY-1:0]     le;
	logic [smpq_pkg::CNT_BITS-1:0]     count_q;
	logic [smpq_pkg::CNT_BITS-1:0]     count_nxt;

	logic                              full;
	logic                              empty;
	logic                              do_insert;
	logic                              do_remove;

	logic                              out_valid_q;
	logic                              res_valid_q;
	logic                              res_empty_q;
	logic                              res_ovf_q;
	logic [smpq_pkg::KEY_BITS-1:0]     res_key_q;
	logic [smpq_pkg::TAG_BITS-1:0]     res_tag_q;
	logic [smpq_pkg::CNT_BITS-1:0]     res_fill_q;

	assign full      = (count_q == smpq_pkg::CNT_BITS'(smpq_pkg::CAPACITY));
	assign empty     = (count_q == '0);
	assign do_insert = (item_op_q == smpq_pkg::OP_ENQUEUE) && !full;
	assign do_remove = (item_op_q == smpq_pkg::OP_DEQUEUE) && !empty;

	assign status.out_free = !out_valid_q || m_tready;

	for (genvar g = 0; g < smpq_pkg::CAPACITY; g++) begin : g_slot
		assign le[g] = (smpq_pkg::CNT_BITS'(g) < count_q) && (key_q[g] <= item_key_q);

		always_comb begin
			key_nxt[g] = key_q[g];
			tag_nxt[g] = tag_q[g];
			if (do_insert && !le[g]) begin
				if (g == 0) begin
					key_nxt[g] = item_key_q;
					tag_nxt[g] = item_tag_q;
				end else if (le[(g == 0) ? 0 : g - 1]) begin
					key_nxt[g] = item_key_q;
					tag_nxt[g] = item_tag_q;
				end else begin
					key_nxt[g] = key_q[(g == 0) ? 0 : g - 1];
					tag_nxt[g] = tag_q[(g == 0) ? 0 : g - 1];
				end
			end else if (do_remove && (g < smpq_pkg::CAPACITY - 1)) begin
				key_nxt[g] = key_q[(g < smpq_pkg::CAPACITY - 1) ? g + 1 : g];
				tag_nxt[g] = tag_q[(g < smpq_pkg::CAPACITY - 1) ? g + 1 : g];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.execute) begin
				key_q[g] <= key_nxt[g];
				tag_q[g] <= tag_nxt[g];
			end
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_insert) begin
			count_nxt = count_q + 1'b1;
		end else if (do_remove) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_op_q  <= s_tuser;
			item_key_q <= s_tdata[smpq_pkg::KEY_BITS-1:0];
			item_tag_q <= s_tdata[smpq_pkg::KEY_BITS +: smpq_pkg::TAG_BITS];
		end
		if (cmd.execute) begin
			res_valid_q <= do_remove;
			res_empty_q <= (item_op_q == smpq_pkg::OP_DEQUEUE) && empty;
			res_ovf_q   <= (item_op_q == smpq_pkg::OP_ENQUEUE) && full;
			res_key_q   <= do_remove ? key_q[0] : '0;
			res_tag_q   <= do_remove ? tag_q[0] : '0;
			res_fill_q  <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.execute) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = smpq_pkg::M_TDATA_BITS'({smpq_pkg::FILL_BITS'(res_fill_q),
		res_tag_q, res_key_q});
	assign m_tuser  = {res_ovf_q, res_empty_q, res_valid_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= smpq_pkg::CNT_BITS'(smpq_pkg::CAPACITY))
		else $error("Entry count exceeds the capacity.");

	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> (!out_valid_q || m_tready))
		else $error("Result overwritten before its transfer.");

	a_exec_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> m_tvalid)
		else $error("Executed item gave no result.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && item_op_q == smpq_pkg::OP_DEQUEUE && empty) |=>
		(res_empty_q && !res_valid_q && count_q == '0))
		else $error("Dequeue from an empty queue misreported.");

endmodule
